@@ sv/lfu_cache_assert.svh @@
// ----------------------------------------------------------------------------
// lfu_cache_assert.svh - assertion macros
// Clocked implication checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_ASSERT_SVH
`define LFU_CACHE_ASSERT_SVH

// same-cycle implication
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg - shared types and constants
// Command codes, sequencer states and the control groups of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	localparam int CAP_BITS   = 5;
	localparam int STAMP_BITS = 48;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE
	} state_t;

	// flags handed from cell to cell along the search chain
	typedef struct packed {
		logic found;
		logic have_victim;
		logic have_free;
	} link_t;

	// write command broadcast to all cells at the end of an item
	typedef struct packed {
		logic hit_upd;
		logic is_put;
		logic ins;
		logic evict;
	} upd_t;

endpackage

`default_nettype wire

@@ sv/lfu_if.sv @@
// ----------------------------------------------------------------------------
// lfu_if - request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfu_in_if #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, command, key, value, input ready);
	modport sink   (input valid, command, key, value, output ready);
endinterface

interface lfu_out_if #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	logic                  evicted;
	logic [KEY_BITS-1:0]   evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

@@ sv/lfu_cell.sv @@
// ----------------------------------------------------------------------------
// lfu_cell - one entry of the store
// Holds one entry and folds it into the running hit / victim / free-slot
// search passed from its left neighbor, registered toward the right.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 16,
	parameter int IDX_BITS   = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [IDX_BITS-1:0]            slot,
	input  logic [KEY_BITS-1:0]            key,
	input  lfu_pkg::link_t                 prev_link,
	input  logic [VALUE_BITS-1:0]          prev_hit_value,
	input  logic [IDX_BITS-1:0]            prev_victim_idx,
	input  logic [COUNT_BITS-1:0]          prev_victim_count,
	input  logic [lfu_pkg::STAMP_BITS-1:0] prev_victim_stamp,
	input  logic [KEY_BITS-1:0]            prev_victim_key,
	input  logic [IDX_BITS-1:0]            prev_free_idx,
	output lfu_pkg::link_t                 next_link,
	output logic [VALUE_BITS-1:0]          next_hit_value,
	output logic [IDX_BITS-1:0]            next_victim_idx,
	output logic [COUNT_BITS-1:0]          next_victim_count,
	output logic [lfu_pkg::STAMP_BITS-1:0] next_victim_stamp,
	output logic [KEY_BITS-1:0]            next_victim_key,
	output logic [IDX_BITS-1:0]            next_free_idx,
	input  lfu_pkg::upd_t                  upd,
	input  logic [IDX_BITS-1:0]            victim_idx,
	input  logic [IDX_BITS-1:0]            insert_idx,
	input  logic [VALUE_BITS-1:0]          value,
	input  logic [lfu_pkg::STAMP_BITS-1:0] stamp
);
	import lfu_pkg::*;

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [STAMP_BITS-1:0] stamp_q;

	link_t                 link_q;
	logic [VALUE_BITS-1:0] hit_value_q;
	logic [IDX_BITS-1:0]   victim_idx_q;
	logic [COUNT_BITS-1:0] victim_count_q;
	logic [STAMP_BITS-1:0] victim_stamp_q;
	logic [KEY_BITS-1:0]   victim_key_q;
	logic [IDX_BITS-1:0]   free_idx_q;

	logic match;
	logic take;
	logic free_here;
	logic ins_here;
	logic evict_here;

	assign match = valid_q && (key_q == key);
	// lower count wins, then older stamp; full ties keep the lower slot
	assign take = valid_q && (!prev_link.have_victim ||
		(count_q < prev_victim_count) ||
		((count_q == prev_victim_count) && (stamp_q < prev_victim_stamp)));
	assign free_here  = !valid_q && !prev_link.have_free;
	assign ins_here   = upd.ins && (insert_idx == slot);
	assign evict_here = upd.evict && (victim_idx == slot);

	// search chain stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.found       <= prev_link.found || match;
			link_q.have_victim <= prev_link.have_victim || take;
			link_q.have_free   <= prev_link.have_free || free_here;
		end
	end

	always_ff @(posedge clk) begin
		hit_value_q    <= match ? value_q : prev_hit_value;
		victim_idx_q   <= take ? slot : prev_victim_idx;
		victim_count_q <= take ? count_q : prev_victim_count;
		victim_stamp_q <= take ? stamp_q : prev_victim_stamp;
		victim_key_q   <= take ? key_q : prev_victim_key;
		free_idx_q     <= free_here ? slot : prev_free_idx;
	end

	// entry storage; insert takes priority over eviction of the same slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins_here) begin
			valid_q <= 1'b1;
		end else if (evict_here) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_here) begin
			key_q   <= key;
			value_q <= value;
			count_q <= COUNT_BITS'(1);
			stamp_q <= stamp;
		end else if (upd.hit_upd && match) begin
			if (upd.is_put) begin
				value_q <= value;
			end
			if (count_q != {COUNT_BITS{1'b1}}) begin
				count_q <= count_q + COUNT_BITS'(1);
			end
			stamp_q <= stamp;
		end
	end

	assign next_link         = link_q;
	assign next_hit_value    = hit_value_q;
	assign next_victim_idx   = victim_idx_q;
	assign next_victim_count = victim_count_q;
	assign next_victim_stamp = victim_stamp_q;
	assign next_victim_key   = victim_key_q;
	assign next_free_idx     = free_idx_q;

endmodule

`default_nettype wire

@@ sv/lfu_cache.sv @@
// ----------------------------------------------------------------------------
// lfu_cache - fully associative key/value store, LFU replacement
// Least-frequently-used eviction with oldest-stamp tiebreak, built as a
// chain of entry cells that a search wave runs through.
// ----------------------------------------------------------------------------
//
//  channel   dir  words                                   handshake
//  --------  ---  --------------------------------------  ------------------
//  req       in   command, key, value                     valid/ready
//  rsp       out  hit, read_value, evicted, evicted_key   valid/ready
//  cfg       in   cfg_wdata = capacity_in_use             cfg_we, no stall
//
//  An item moves through an accept state, a search state in which the
//  search wave walks the chain one cell per cycle, and an update state.
//  The update waits while the previous response word is still unclaimed.
//  Reset clears valid bits, occupancy, stamp counter and the sequencer;
//  capacity returns to 16 (clamped to MAX_ENTRIES).
//  req.ready is high only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache #(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 32,
	parameter int VALUE_BITS  = 32,
	parameter int COUNT_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata,
	lfu_in_if.sink                      req,
	lfu_out_if.source                   rsp
);
	import lfu_pkg::*;

	localparam int IDX_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_BITS = $clog2(MAX_ENTRIES + 1);
	localparam int CW       = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
	localparam logic [IDX_BITS-1:0] SWEEP_LAST = IDX_BITS'(MAX_ENTRIES - 1);

	// sequencer
	state_t              state_q, state_d;
	logic [IDX_BITS-1:0] sweep_q;
	logic                ready_c;
	logic                commit;
	logic                out_free;

	// held item and bookkeeping
	logic                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [OCC_BITS-1:0]   occ_q;
	logic [STAMP_BITS-1:0] stamp_q;

	// response register
	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic                  evicted_q;
	logic [KEY_BITS-1:0]   evicted_key_q;

	// search chain taps, index 0 is the empty seed
	link_t                 link      [MAX_ENTRIES+1];
	logic [VALUE_BITS-1:0] hit_value [MAX_ENTRIES+1];
	logic [IDX_BITS-1:0]   vic_idx   [MAX_ENTRIES+1];
	logic [COUNT_BITS-1:0] vic_count [MAX_ENTRIES+1];
	logic [STAMP_BITS-1:0] vic_stamp [MAX_ENTRIES+1];
	logic [KEY_BITS-1:0]   vic_key   [MAX_ENTRIES+1];
	logic [IDX_BITS-1:0]   free_idx  [MAX_ENTRIES+1];

	// update decisions
	upd_t                upd;
	logic                cap_zero;
	logic [CW-1:0]       cap_ext;
	logic [CW-1:0]       cap_eff;
	logic                full;
	logic                is_put;
	logic                hit_c;
	logic                miss_put;
	logic                do_evict;
	logic                do_ins;
	logic [IDX_BITS-1:0] ins_idx;
	link_t               tail;

	assign link[0]      = '0;
	assign hit_value[0] = '0;
	assign vic_idx[0]   = '0;
	assign vic_count[0] = '0;
	assign vic_stamp[0] = '0;
	assign vic_key[0]   = '0;
	assign free_idx[0]  = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lfu_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.COUNT_BITS (COUNT_BITS),
			.IDX_BITS   (IDX_BITS)
		) u_cell (
			.clk               (clk),
			.arst_n            (arst_n),
			.slot              (IDX_BITS'(i)),
			.key               (key_q),
			.prev_link         (link[i]),
			.prev_hit_value    (hit_value[i]),
			.prev_victim_idx   (vic_idx[i]),
			.prev_victim_count (vic_count[i]),
			.prev_victim_stamp (vic_stamp[i]),
			.prev_victim_key   (vic_key[i]),
			.prev_free_idx     (free_idx[i]),
			.next_link         (link[i+1]),
			.next_hit_value    (hit_value[i+1]),
			.next_victim_idx   (vic_idx[i+1]),
			.next_victim_count (vic_count[i+1]),
			.next_victim_stamp (vic_stamp[i+1]),
			.next_victim_key   (vic_key[i+1]),
			.next_free_idx     (free_idx[i+1]),
			.upd               (upd),
			.victim_idx        (vic_idx[MAX_ENTRIES]),
			.insert_idx        (ins_idx),
			.value             (value_q),
			.stamp             (stamp_q)
		);
	end

	// decisions from the end of the chain
	assign tail     = link[MAX_ENTRIES];
	assign cap_zero = (cap_q == '0);
	assign cap_ext  = CW'(cap_q);
	assign cap_eff  = (cap_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_ext;
	assign full     = (CW'(occ_q) >= cap_eff);
	assign is_put   = (cmd_q == CMD_PUT);
	assign hit_c    = !cap_zero && tail.found;
	assign miss_put = !cap_zero && is_put && !tail.found;
	assign do_evict = miss_put && full && tail.have_victim;
	assign do_ins   = miss_put && (do_evict || tail.have_free);

	// the freed victim slot competes with the first empty slot
	always_comb begin
		ins_idx = free_idx[MAX_ENTRIES];
		if (do_evict && (!tail.have_free ||
			(vic_idx[MAX_ENTRIES] < free_idx[MAX_ENTRIES]))) begin
			ins_idx = vic_idx[MAX_ENTRIES];
		end
	end

	always_comb begin
		upd.hit_upd = commit && hit_c;
		upd.is_put  = is_put;
		upd.ins     = commit && do_ins;
		upd.evict   = commit && do_evict;
	end

	// sequencer
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ready_c = 1'b0;
		commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ready_c = 1'b1;
				if (req.valid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (sweep_q == SWEEP_LAST) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				commit = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req.ready = ready_c;

	// wave position: one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (state_q == ST_SEARCH) begin
			sweep_q <= sweep_q + IDX_BITS'(1);
		end else begin
			sweep_q <= '0;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (req.valid && ready_c) begin
			cmd_q   <= req.command;
			key_q   <= req.key;
			value_q <= req.value;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// occupancy and stamp; an item draws at most one stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			stamp_q <= '0;
		end else if (commit) begin
			if (do_ins && !do_evict) begin
				occ_q <= occ_q + OCC_BITS'(1);
			end
			if (hit_c || do_ins) begin
				stamp_q <= stamp_q + STAMP_BITS'(1);
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q         <= hit_c;
			read_value_q  <= (hit_c && !is_put) ? hit_value[MAX_ENTRIES] : '0;
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? vic_key[MAX_ENTRIES] : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.evicted     = evicted_q;
	assign rsp.evicted_key = evicted_key_q;

	`include "lfu_cache_assert.svh"

	`LFU_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ_q <= OCC_BITS'(MAX_ENTRIES), "occupancy over depth")
	`LFU_ASSERT_IMP(a_evict_refills, clk, arst_n, commit && do_evict, do_ins, "eviction without insert")
	`LFU_ASSERT_NXT(a_commit_resp, clk, arst_n, commit, rsp.valid, "commit without response")
	`LFU_ASSERT_NXT(a_stamp_hold, clk, arst_n, !commit, $stable(stamp_q), "stamp moved outside commit")

endmodule

`default_nettype wire

@@ sim/lfu_cache_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_tb - self-checking bench for the LFU key/value store
// Directed table, then random get/put traffic over several capacity settings
// and flow-control phases; every response word is checked against a local
// model of the store or, for typed table rows, against the table entry.
// ----------------------------------------------------------------------------

module lfu_cache_tb;

	import lfu_pkg::*;

	localparam int MAX_ENTRIES   = 16;
	localparam int KEY_BITS      = 32;
	localparam int VALUE_BITS    = 32;
	localparam int COUNT_BITS    = 16;

	// settle for longer than one item takes to pass through the block
	localparam int SETTLE_CYCLES = MAX_ENTRIES + 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int NUM_PHASES    = 8;
	localparam int POOL_MAX      = 20;

	// one response word
	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
		logic [KEY_BITS-1:0]   evicted_key;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ROW_GET,
		ROW_PUT,
		ROW_CFG
	} row_kind_t;

	// directed row: cfg rows carry the capacity in the value field
	typedef struct packed {
		row_kind_t             kind;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic                  typed;
		rsp_word_t             want;
	} dir_row_t;

	localparam rsp_word_t RSP_NONE = '0;
	localparam int        DIR_ROWS = 25;

	// Typed expectations only where they are obvious: fresh store, extremes,
	// and a disabled store. Everything else goes through the model.
	dir_row_t dir_tab [0:DIR_ROWS-1] = '{
		'{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, RSP_NONE},
		'{ROW_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, RSP_NONE},
		'{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
		'{ROW_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, RSP_NONE},
		// put hit: value replaced, read_value stays zero
		'{ROW_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
			'{1'b1, 32'h0, 1'b0, 32'h0}},
		'{ROW_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
		'{ROW_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, RSP_NONE},
		// shrink to the current fill, then force evictions
		'{ROW_CFG, 32'h0, 32'd2, 1'b0, RSP_NONE},
		'{ROW_PUT, 32'h0000_0005, 32'hA5A5_A5A5, 1'b0, RSP_NONE},
		'{ROW_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, RSP_NONE},
		'{ROW_PUT, 32'h0000_0006, 32'h5A5A_5A5A, 1'b0, RSP_NONE},
		// disabled store: all zero, contents kept
		'{ROW_CFG, 32'h0, 32'd0, 1'b0, RSP_NONE},
		'{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, RSP_NONE},
		'{ROW_PUT, 32'h0000_0007, 32'h0000_0001, 1'b1, RSP_NONE},
		// above MAX_ENTRIES clamps; old entries visible again
		'{ROW_CFG, 32'h0, 32'd31, 1'b0, RSP_NONE},
		'{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, RSP_NONE},
		'{ROW_PUT, 32'h0000_0008, 32'h0000_0002, 1'b0, RSP_NONE},
		'{ROW_PUT, 32'h0000_0009, 32'h0000_0003, 1'b0, RSP_NONE},
		// capacity below occupancy: one eviction per new key, count-1 tie
		'{ROW_CFG, 32'h0, 32'd1, 1'b0, RSP_NONE},
		'{ROW_PUT, 32'h0000_000A, 32'h0000_0004, 1'b0, RSP_NONE},
		'{ROW_PUT, 32'h0000_000B, 32'h0000_0005, 1'b0, RSP_NONE},
		'{ROW_GET, 32'h0000_0006, 32'h0000_0000, 1'b0, RSP_NONE},
		'{ROW_CFG, 32'h0, 32'd16, 1'b0, RSP_NONE},
		'{ROW_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, RSP_NONE},
		'{ROW_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, RSP_NONE}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CAP_BITS-1:0] cfg_wdata;

	lfu_in_if  #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_ch ();
	lfu_out_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) rsp_ch ();

	lfu_cache #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// ------------------------------------------------------------------------
	// Store model: own copy of entries, stamps, fill and capacity
	// ------------------------------------------------------------------------
	logic                  m_valid [MAX_ENTRIES];
	logic [KEY_BITS-1:0]   m_key   [MAX_ENTRIES];
	logic [VALUE_BITS-1:0] m_value [MAX_ENTRIES];
	logic [COUNT_BITS-1:0] m_count [MAX_ENTRIES];
	logic [STAMP_BITS-1:0] m_stamp [MAX_ENTRIES];
	logic [STAMP_BITS-1:0] m_stamp_ctr;
	int                    m_occ;
	int                    m_cap;

	rsp_word_t pending_rsp_q [$];

	int send_idle_pct;
	int rsp_stall_pct;
	int hold_reqs;
	int mismatch_cnt;
	int cycle_cnt;

	// One access against the model: returns the response word and updates
	// the model state exactly as the block should.
	function automatic rsp_word_t lfu_access(input logic cmd,
			input logic [KEY_BITS-1:0] k, input logic [VALUE_BITS-1:0] v);
		rsp_word_t r;
		int        lim;
		int        slot;
		int        victim;
		bit        found;
		bit        have;
		r   = '0;
		lim = (m_cap > MAX_ENTRIES) ? MAX_ENTRIES : m_cap;
		if (lim == 0)
			return r;

		found = 1'b0;
		slot  = 0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (!found && m_valid[i] && m_key[i] == k) begin
				found = 1'b1;
				slot  = i;
			end
		end

		if (found) begin
			r.hit = 1'b1;
			if (cmd == CMD_PUT)
				m_value[slot] = v;
			else
				r.read_value = m_value[slot];
			// count saturates, stamp always renewed
			if (m_count[slot] != '1)
				m_count[slot] = m_count[slot] + COUNT_BITS'(1);
			m_stamp[slot] = m_stamp_ctr;
			m_stamp_ctr   = m_stamp_ctr + STAMP_BITS'(1);
			return r;
		end

		if (cmd == CMD_GET)
			return r;

		// full: lowest count, then oldest stamp
		if (m_occ >= lim) begin
			have   = 1'b0;
			victim = 0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (m_valid[i] && (!have || m_count[i] < m_count[victim] ||
						(m_count[i] == m_count[victim] &&
						 m_stamp[i] < m_stamp[victim]))) begin
					have   = 1'b1;
					victim = i;
				end
			end
			if (have) begin
				m_valid[victim] = 1'b0;
				r.evicted       = 1'b1;
				r.evicted_key   = m_key[victim];
				if (m_occ > 0)
					m_occ--;
			end
		end

		// lowest free slot takes the new key
		found = 1'b0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (!found && !m_valid[i]) begin
				found       = 1'b1;
				m_valid[i]  = 1'b1;
				m_key[i]    = k;
				m_value[i]  = v;
				m_count[i]  = COUNT_BITS'(1);
				m_stamp[i]  = m_stamp_ctr;
				m_stamp_ctr = m_stamp_ctr + STAMP_BITS'(1);
				m_occ++;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: hard stop well past the slowest legal run
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Response side ready. A hold request from the stimulus thread forces a
	// long stall counted here; otherwise ready follows the stall percentage.
	// ------------------------------------------------------------------------
	initial begin : rsp_ready_gen
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Response checker: each accepted word against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp_q.size() == 0) begin
				$error("response word with no item outstanding");
				mismatch_cnt++;
			end else begin
				want = pending_rsp_q.pop_front();
				if (rsp_ch.hit !== want.hit) begin
					$error("hit: expected %0h, got %0h", want.hit, rsp_ch.hit);
					mismatch_cnt++;
				end
				if (rsp_ch.read_value !== want.read_value) begin
					$error("read_value: expected %0h, got %0h",
						want.read_value, rsp_ch.read_value);
					mismatch_cnt++;
				end
				if (rsp_ch.evicted !== want.evicted) begin
					$error("evicted: expected %0h, got %0h",
						want.evicted, rsp_ch.evicted);
					mismatch_cnt++;
				end
				if (rsp_ch.evicted_key !== want.evicted_key) begin
					$error("evicted_key: expected %0h, got %0h",
						want.evicted_key, rsp_ch.evicted_key);
					mismatch_cnt++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request driving. Called at an accept edge (or when idle); either drives
	// the next word straight away or drops valid for a random gap first, so
	// valid only gets one assignment per edge.
	// ------------------------------------------------------------------------
	task automatic send_word(input logic cmd, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.key     <= k;
		req_ch.value   <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_rsp_q.push_back(lfu_access(cmd, k, v));
	endtask

	// stop offering and wait for every outstanding response
	task automatic drain_rsp();
		req_ch.valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	// capacity write, only with the block idle
	task automatic cfg_write(input logic [CAP_BITS-1:0] c);
		drain_rsp();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		m_cap      = int'(c);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int                  ph_cap   [NUM_PHASES];
		int                  ph_items [NUM_PHASES];
		logic [KEY_BITS-1:0] key_pool [POOL_MAX];
		int                  pool_n;
		int                  idx;
		logic                cmd;
		logic [KEY_BITS-1:0] k;

		ph_cap   = '{4, 16, 1, 0, 31, 8, 2, 17};
		ph_items = '{60, 70, 50, 20, 60, 70, 50, 70};

		for (int i = 0; i < MAX_ENTRIES; i++) begin
			m_valid[i] = 1'b0;
			m_key[i]   = '0;
			m_value[i] = '0;
			m_count[i] = '0;
			m_stamp[i] = '0;
		end
		m_stamp_ctr   = '0;
		m_occ         = 0;
		m_cap         = int'(CAP_RESET);
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_reqs     = 0;
		mismatch_cnt  = 0;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= CAP_RESET;
		req_ch.valid   <= 1'b0;
		req_ch.command <= CMD_GET;
		req_ch.key     <= '0;
		req_ch.value   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_tab[r].kind == ROW_CFG) begin
				cfg_write(dir_tab[r].value[CAP_BITS-1:0]);
			end else begin
				send_word((dir_tab[r].kind == ROW_PUT) ? CMD_PUT : CMD_GET,
					dir_tab[r].key, dir_tab[r].value);
				if (dir_tab[r].typed)
					pending_rsp_q[$] = dir_tab[r].want;
			end
		end

		// random phases: capacity per phase, flow-control mode cycles
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			cfg_write(ph_cap[ph][CAP_BITS-1:0]);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 80;
					rsp_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rsp_stall_pct = 80;
				end
				default: begin
					send_idle_pct = 26;
					rsp_stall_pct = 26;
				end
			endcase

			// small hot set a bit larger than the capacity, so hits,
			// count build-up and evictions all happen often
			pool_n = ((ph_cap[ph] > MAX_ENTRIES) ? MAX_ENTRIES : ph_cap[ph]) + 4;
			for (int j = 0; j < POOL_MAX; j++)
				key_pool[j] = $urandom;
			if (ph % 2 == 0) begin
				key_pool[0] = '0;
				key_pool[1] = '1;
			end

			for (int i = 0; i < ph_items[ph]; i++) begin
				// long response hold while requests keep coming
				if (ph % 4 == 0 && i == 10)
					hold_reqs++;
				// sender pause until everything is back
				if (ph % 2 == 1 && i == ph_items[ph] / 2)
					drain_rsp();

				// skewed pick: low pool indexes are hotter
				idx = $urandom_range($urandom_range(pool_n - 1));
				k   = ($urandom_range(99) < 85) ? key_pool[idx] : $urandom;
				cmd = ($urandom_range(99) < 45) ? CMD_PUT : CMD_GET;
				send_word(cmd, k, $urandom);
			end
		end

		drain_rsp();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
